// File: rtl/pcbs_pkg.sv
// Shared types and constants for the burn-in power cycling sequencer.
`default_nettype none
package pcbs_pkg;

	// Configuration register file geometry.
	localparam int REG_W     = 26;
	localparam int REG_IDX_W = 2;

	// Register indexes.
	localparam logic [REG_IDX_W-1:0] REG_ON_TIME    = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_OFF_TIME   = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_SELFCHECK  = 2'd2;

	// Register reset values in milliseconds.
	localparam logic [REG_W-1:0] ON_TIME_RST   = REG_W'(1000 * 60 * 10);
	localparam logic [REG_W-1:0] OFF_TIME_RST  = REG_W'(1000 * 10);
	localparam logic [REG_W-1:0] SELFCHECK_RST = REG_W'(8000);

	// Item kinds.
	localparam int KIND_W = 3;
	localparam logic [KIND_W-1:0] KIND_TICK      = 3'd0;
	localparam logic [KIND_W-1:0] KIND_START     = 3'd1;
	localparam logic [KIND_W-1:0] KIND_STOP      = 3'd2;
	localparam logic [KIND_W-1:0] KIND_RELAY_ON  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_RELAY_OFF = 3'd4;

	// Result field widths.
	localparam int PHASE_W = 2;
	localparam int OUT_CNT_W = 16;

	// Width of the lamp confirmation countdown.
	localparam int CONF_W = 2;

	// Parameter defaults.
	localparam int COUNT_WIDTH_DEF   = 16;
	localparam int TIMER_WIDTH_DEF   = 26;
	localparam int CONFIRM_TICKS_DEF = 2;

	// Configuration register contents.
	typedef struct packed {
		logic [REG_W-1:0] on_time;
		logic [REG_W-1:0] off_time;
		logic [REG_W-1:0] selfcheck_time;
	} cfg_t;

	// Lamp checker control from the sequencer, already qualified by the transfer.
	typedef struct packed {
		logic watch;
		logic clear;
	} lamp_ctrl_t;

endpackage
`default_nettype wire

// File: rtl/power_cycle_burnin_sequencer_unit.sv
// Burn-in power cycling sequencer, top level.
// An input item passes the input register, then the state update; the sequencer and lamp state
// registers hold each result. Throughput: one item per cycle while out_stall is low.
// An input item is taken while a result waits, held in the input register.
// Asynchronous active-low reset returns to idle, relay off, counters zero, default times.
`default_nettype none
module power_cycle_burnin_sequencer_unit #(
	parameter int COUNT_WIDTH   = pcbs_pkg::COUNT_WIDTH_DEF,
	parameter int TIMER_WIDTH   = pcbs_pkg::TIMER_WIDTH_DEF,
	parameter int CONFIRM_TICKS = pcbs_pkg::CONFIRM_TICKS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           wr_en,
	input  wire logic [pcbs_pkg::REG_IDX_W-1:0] wr_index,
	input  wire logic [pcbs_pkg::REG_W-1:0]     wr_data,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [pcbs_pkg::KIND_W-1:0]    kind,
	input  wire logic                           lamp1_on,
	input  wire logic                           lamp2_on,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic                                relay_drive,
	output logic [pcbs_pkg::PHASE_W-1:0]        phase_now,
	output logic [pcbs_pkg::OUT_CNT_W-1:0]      rounds_done,
	output logic [pcbs_pkg::OUT_CNT_W-1:0]      lamp1_faults,
	output logic [pcbs_pkg::OUT_CNT_W-1:0]      lamp2_faults,
	output logic                                round_end
);

	logic                           valid_s1;
	logic [pcbs_pkg::KIND_W-1:0]    kind_s1;
	logic                           lamp1_s1;
	logic                           lamp2_s1;
	logic                           out_valid_q;
	logic                           adv;
	logic                           in_xfer;

	pcbs_pkg::cfg_t                 cfg;
	pcbs_pkg::lamp_ctrl_t           lamp_ctrl;
	logic [COUNT_WIDTH-1:0]         round_count;
	logic [COUNT_WIDTH-1:0]         fault1;
	logic [COUNT_WIDTH-1:0]         fault2;

	// The held item moves into the state when the result slot is free or being taken.
	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign in_xfer  = in_valid && !in_stall;

	// Input register valid and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_xfer) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Input payload register.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			kind_s1  <= kind;
			lamp1_s1 <= lamp1_on;
			lamp2_s1 <= lamp2_on;
		end
	end

	pcbs_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	pcbs_seq #(
		.COUNT_WIDTH (COUNT_WIDTH),
		.TIMER_WIDTH (TIMER_WIDTH)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.kind        (kind_s1),
		.cfg         (cfg),
		.lamp_ctrl   (lamp_ctrl),
		.relay       (relay_drive),
		.phase       (phase_now),
		.round_count (round_count),
		.round_end   (round_end)
	);

	pcbs_lamp #(
		.COUNT_WIDTH   (COUNT_WIDTH),
		.CONFIRM_TICKS (CONFIRM_TICKS)
	) u_lamp1 (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (lamp_ctrl),
		.lit         (lamp1_s1),
		.fault_count (fault1)
	);

	pcbs_lamp #(
		.COUNT_WIDTH   (COUNT_WIDTH),
		.CONFIRM_TICKS (CONFIRM_TICKS)
	) u_lamp2 (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (lamp_ctrl),
		.lit         (lamp2_s1),
		.fault_count (fault2)
	);

	// Counters are reported in the fixed result width.
	assign out_valid    = out_valid_q;
	assign rounds_done  = pcbs_pkg::OUT_CNT_W'(round_count);
	assign lamp1_faults = pcbs_pkg::OUT_CNT_W'(fault1);
	assign lamp2_faults = pcbs_pkg::OUT_CNT_W'(fault2);

endmodule
`default_nettype wire

// File: rtl/pcbs_cfg.sv
// Configuration registers for on, off and self-check times.
`default_nettype none
module pcbs_cfg (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         wr_en,
	input  wire logic [pcbs_pkg::REG_IDX_W-1:0] wr_index,
	input  wire logic [pcbs_pkg::REG_W-1:0]   wr_data,
	output pcbs_pkg::cfg_t                    cfg
);

	pcbs_pkg::cfg_t cfg_q;

	// Writes to an index beyond the register list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.on_time        <= pcbs_pkg::ON_TIME_RST;
			cfg_q.off_time       <= pcbs_pkg::OFF_TIME_RST;
			cfg_q.selfcheck_time <= pcbs_pkg::SELFCHECK_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				pcbs_pkg::REG_ON_TIME:   cfg_q.on_time        <= wr_data;
				pcbs_pkg::REG_OFF_TIME:  cfg_q.off_time       <= wr_data;
				pcbs_pkg::REG_SELFCHECK: cfg_q.selfcheck_time <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// File: rtl/pcbs_lamp.sv
// Fault confirmation and saturating fault counter for one warning lamp.
`default_nettype none
module pcbs_lamp #(
	parameter int COUNT_WIDTH   = pcbs_pkg::COUNT_WIDTH_DEF,
	parameter int CONFIRM_TICKS = pcbs_pkg::CONFIRM_TICKS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire pcbs_pkg::lamp_ctrl_t   ctrl,
	input  wire logic                   lit,
	output logic [COUNT_WIDTH-1:0]      fault_count
);

	localparam logic [pcbs_pkg::CONF_W-1:0] CONF_LOAD = pcbs_pkg::CONF_W'(CONFIRM_TICKS);
	localparam logic [pcbs_pkg::CONF_W-1:0] CONF_ONE  = pcbs_pkg::CONF_W'(1);

	logic                          seen_q;
	logic [pcbs_pkg::CONF_W-1:0]   wait_q;
	logic [COUNT_WIDTH-1:0]        count_q;

	// A lit sample opens a check; the lamp must still be lit when the wait ends.
	// Clearing at power on or power off drops the flag and any pending check.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q  <= 1'b0;
			wait_q  <= '0;
			count_q <= '0;
		end else begin
			if (ctrl.watch && !seen_q) begin
				if (wait_q == '0) begin
					if (lit) begin
						wait_q <= CONF_LOAD;
					end
				end else begin
					wait_q <= wait_q - CONF_ONE;
					if (wait_q == CONF_ONE && lit) begin
						seen_q <= 1'b1;
						if (count_q != '1) begin
							count_q <= count_q + COUNT_WIDTH'(1);
						end
					end
				end
			end
			if (ctrl.clear) begin
				seen_q <= 1'b0;
				wait_q <= '0;
			end
		end
	end

	assign fault_count = count_q;

endmodule
`default_nettype wire

// File: rtl/pcbs_seq.sv
// Round sequencer: phase control, relay, on and phase timers, round counter.
`default_nettype none
module pcbs_seq #(
	parameter int COUNT_WIDTH = pcbs_pkg::COUNT_WIDTH_DEF,
	parameter int TIMER_WIDTH = pcbs_pkg::TIMER_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          adv,
	input  wire logic [pcbs_pkg::KIND_W-1:0]   kind,
	input  wire pcbs_pkg::cfg_t                cfg,
	output pcbs_pkg::lamp_ctrl_t               lamp_ctrl,
	output logic                               relay,
	output logic [pcbs_pkg::PHASE_W-1:0]       phase,
	output logic [COUNT_WIDTH-1:0]             round_count,
	output logic                               round_end
);

	typedef enum logic [pcbs_pkg::PHASE_W-1:0] {
		PH_IDLE  = 2'd0,
		PH_CHECK = 2'd1,
		PH_WATCH = 2'd2,
		PH_OFF   = 2'd3
	} phase_t;

	phase_t                  phase_q;
	logic                    running_q;
	logic                    relay_q;
	logic                    ended_q;
	logic [TIMER_WIDTH-1:0]  on_rem_q;
	logic [TIMER_WIDTH-1:0]  ph_rem_q;
	logic [COUNT_WIDTH-1:0]  round_q;

	logic                    tick;
	logic                    on_zero;
	logic [TIMER_WIDTH-1:0]  on_dec;
	logic [TIMER_WIDTH-1:0]  ph_dec;

	// Timer countdowns that hold at zero.
	assign tick    = adv && (kind == pcbs_pkg::KIND_TICK);
	assign on_zero = (on_rem_q == '0);
	assign on_dec  = on_zero ? '0 : on_rem_q - TIMER_WIDTH'(1);
	assign ph_dec  = (ph_rem_q == '0) ? '0 : ph_rem_q - TIMER_WIDTH'(1);

	// Lamp checks run during monitoring while on time remains; the lamp state
	// is cleared when a round starts and when monitoring switches the relay off.
	always_comb begin
		lamp_ctrl.watch = tick && (phase_q == PH_WATCH) && !on_zero;
		lamp_ctrl.clear = tick && (((phase_q == PH_IDLE) && running_q) ||
			((phase_q == PH_WATCH) && (on_zero || !running_q)));
	end

	// Sequencer state; the registers also form the result of each transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			running_q <= 1'b0;
			relay_q   <= 1'b0;
			ended_q   <= 1'b0;
			on_rem_q  <= '0;
			ph_rem_q  <= '0;
			round_q   <= '0;
		end else if (adv) begin
			ended_q <= 1'b0;
			unique case (kind)
				pcbs_pkg::KIND_START:     running_q <= 1'b1;
				pcbs_pkg::KIND_STOP:      running_q <= 1'b0;
				pcbs_pkg::KIND_RELAY_ON:  relay_q   <= 1'b1;
				pcbs_pkg::KIND_RELAY_OFF: relay_q   <= 1'b0;
				pcbs_pkg::KIND_TICK: begin
					unique case (phase_q)
						PH_IDLE: begin
							if (running_q) begin
								if (round_q != '1) begin
									round_q <= round_q + COUNT_WIDTH'(1);
								end
								relay_q  <= 1'b1;
								on_rem_q <= TIMER_WIDTH'(cfg.on_time);
								ph_rem_q <= TIMER_WIDTH'(cfg.selfcheck_time);
								phase_q  <= PH_CHECK;
							end
						end
						PH_CHECK: begin
							on_rem_q <= on_dec;
							ph_rem_q <= ph_dec;
							if (ph_dec == '0) begin
								phase_q <= PH_WATCH;
							end
						end
						PH_WATCH: begin
							on_rem_q <= on_dec;
							if (on_zero || !running_q) begin
								relay_q  <= 1'b0;
								ph_rem_q <= TIMER_WIDTH'(cfg.off_time);
								phase_q  <= PH_OFF;
							end
						end
						PH_OFF: begin
							ph_rem_q <= ph_dec;
							if (ph_dec == '0) begin
								ended_q <= 1'b1;
								phase_q <= PH_IDLE;
							end
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

	assign relay       = relay_q;
	assign phase       = phase_q;
	assign round_count = round_q;
	assign round_end   = ended_q;

endmodule
`default_nettype wire

// File: sim/tb_power_cycle_burnin_sequencer_unit.sv
// Self-checking testbench for the burn-in power cycling sequencer top level.
`timescale 1ns / 100ps
`default_nettype none
module tb_power_cycle_burnin_sequencer_unit;

	// Cycles without any transfer or register write before the run is abandoned.
	localparam int QUIET_LIMIT = 2000;
	localparam logic [pcbs_pkg::REG_W-1:0] REG_MAX = '1;
	localparam logic [pcbs_pkg::OUT_CNT_W-1:0] CNT_MAX = '1;

	typedef enum logic [pcbs_pkg::PHASE_W-1:0] {
		PH_IDLE      = 2'd0,
		PH_SELFCHECK = 2'd1,
		PH_MONITOR   = 2'd2,
		PH_OFFWAIT   = 2'd3
	} seq_phase_t;

	// One result item as seen on the output ports.
	typedef struct packed {
		logic                           relay;
		logic [pcbs_pkg::PHASE_W-1:0]   phase;
		logic [pcbs_pkg::OUT_CNT_W-1:0] rounds;
		logic [pcbs_pkg::OUT_CNT_W-1:0] lamp1_cnt;
		logic [pcbs_pkg::OUT_CNT_W-1:0] lamp2_cnt;
		logic                           ended;
	} status_t;

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [pcbs_pkg::REG_IDX_W-1:0] wr_index;
	logic [pcbs_pkg::REG_W-1:0] wr_data;
	logic in_valid;
	logic in_stall;
	logic [pcbs_pkg::KIND_W-1:0] kind;
	logic lamp1_on;
	logic lamp2_on;
	logic out_valid;
	logic out_stall;
	logic relay_drive;
	logic [pcbs_pkg::PHASE_W-1:0] phase_now;
	logic [pcbs_pkg::OUT_CNT_W-1:0] rounds_done;
	logic [pcbs_pkg::OUT_CNT_W-1:0] lamp1_faults;
	logic [pcbs_pkg::OUT_CNT_W-1:0] lamp2_faults;
	logic round_end;

	power_cycle_burnin_sequencer_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.lamp1_on(lamp1_on),
		.lamp2_on(lamp2_on),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.relay_drive(relay_drive),
		.phase_now(phase_now),
		.rounds_done(rounds_done),
		.lamp1_faults(lamp1_faults),
		.lamp2_faults(lamp2_faults),
		.round_end(round_end)
	);

	// Sequencer state mirrored by the predictor.
	pcbs_pkg::cfg_t sched_cfg;
	logic running_q;
	seq_phase_t seq_phase;
	logic [pcbs_pkg::REG_W-1:0] on_left;
	logic [pcbs_pkg::REG_W-1:0] phase_left;
	logic fault_seen [2];
	logic [pcbs_pkg::CONF_W-1:0] confirm_left [2];
	logic [pcbs_pkg::OUT_CNT_W-1:0] round_cnt;
	logic [pcbs_pkg::OUT_CNT_W-1:0] fault_cnt [2];
	logic relay_q;

	status_t expected_status [$];
	status_t seen_status;
	int mismatch_count;
	int items_sent;
	int results_checked;
	int quiet_cycles;
	int stall_left;
	bit in_idle_on;
	bit out_idle_on;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [pcbs_pkg::OUT_CNT_W-1:0] count_up(
			logic [pcbs_pkg::OUT_CNT_W-1:0] v);
		return (v == CNT_MAX) ? v : v + 1'b1;
	endfunction

	function automatic logic [pcbs_pkg::REG_W-1:0] count_down(logic [pcbs_pkg::REG_W-1:0] v);
		return (v != '0) ? v - 1'b1 : v;
	endfunction

	// A lit lamp arms a confirmation wait; a fault counts if it is still lit when the wait ends.
	function automatic void watch_lamp(int i, logic lit);
		if (!fault_seen[i]) begin
			if (confirm_left[i] == '0) begin
				if (lit)
					confirm_left[i] = pcbs_pkg::CONF_W'(pcbs_pkg::CONFIRM_TICKS_DEF);
			end else begin
				confirm_left[i] = confirm_left[i] - 1'b1;
				if (confirm_left[i] == '0 && lit) begin
					fault_cnt[i] = count_up(fault_cnt[i]);
					fault_seen[i] = 1'b1;
				end
			end
		end
	endfunction

	function automatic void cut_power();
		relay_q = 1'b0;
		fault_seen[0] = 1'b0;
		fault_seen[1] = 1'b0;
		confirm_left[0] = '0;
		confirm_left[1] = '0;
		phase_left = sched_cfg.off_time;
		seq_phase = PH_OFFWAIT;
	endfunction

	// Advances the mirrored sequencer by one item and returns the status it must report.
	function automatic status_t advance_sequencer(logic [pcbs_pkg::KIND_W-1:0] k, logic l1,
			logic l2);
		logic ended = 1'b0;
		case (k)
			pcbs_pkg::KIND_START: running_q = 1'b1;
			pcbs_pkg::KIND_STOP: running_q = 1'b0;
			pcbs_pkg::KIND_RELAY_ON: relay_q = 1'b1;
			pcbs_pkg::KIND_RELAY_OFF: relay_q = 1'b0;
			pcbs_pkg::KIND_TICK: begin
				case (seq_phase)
					PH_IDLE: begin
						if (running_q) begin
							round_cnt = count_up(round_cnt);
							relay_q = 1'b1;
							on_left = sched_cfg.on_time;
							phase_left = sched_cfg.selfcheck_time;
							fault_seen[0] = 1'b0;
							fault_seen[1] = 1'b0;
							confirm_left[0] = '0;
							confirm_left[1] = '0;
							seq_phase = PH_SELFCHECK;
						end
					end
					PH_SELFCHECK: begin
						on_left = count_down(on_left);
						phase_left = count_down(phase_left);
						if (phase_left == '0)
							seq_phase = PH_MONITOR;
					end
					PH_MONITOR: begin
						if (on_left == '0) begin
							cut_power();
						end else begin
							watch_lamp(0, l1);
							watch_lamp(1, l2);
							on_left = on_left - 1'b1;
							if (!running_q)
								cut_power();
						end
					end
					default: begin
						phase_left = count_down(phase_left);
						if (phase_left == '0) begin
							ended = 1'b1;
							seq_phase = PH_IDLE;
						end
					end
				endcase
			end
			default: ;
		endcase
		return '{relay_q, seq_phase, round_cnt, fault_cnt[0], fault_cnt[1], ended};
	endfunction

	// Sends one item, with an occasional hold-off first, and records its expected status.
	task automatic send_item(logic [pcbs_pkg::KIND_W-1:0] k, logic l1, logic l2);
		int gap;
		gap = (in_idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 19) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		lamp1_on <= l1;
		lamp2_on <= l2;
		do @(posedge clk); while (in_stall);
		expected_status.push_back(advance_sequencer(k, l1, l2));
		items_sent++;
	endtask

	// Holds the sender off until every expected status has arrived.
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_status.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_register(logic [pcbs_pkg::REG_IDX_W-1:0] idx,
			logic [pcbs_pkg::REG_W-1:0] value);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		@(negedge clk);
		wr_en <= 1'b0;
		case (idx)
			pcbs_pkg::REG_ON_TIME: sched_cfg.on_time = value;
			pcbs_pkg::REG_OFF_TIME: sched_cfg.off_time = value;
			pcbs_pkg::REG_SELFCHECK: sched_cfg.selfcheck_time = value;
			default: ;
		endcase
	endtask

	task automatic program_times(logic [pcbs_pkg::REG_W-1:0] on_ms,
			logic [pcbs_pkg::REG_W-1:0] off_ms, logic [pcbs_pkg::REG_W-1:0] check_ms);
		wait_drained();
		write_register(pcbs_pkg::REG_ON_TIME, on_ms);
		write_register(pcbs_pkg::REG_OFF_TIME, off_ms);
		write_register(pcbs_pkg::REG_SELFCHECK, check_ms);
	endtask

	// Commands and unused kinds while idle and not running; ticks must not start a round.
	task automatic test_idle_commands();
		send_item(pcbs_pkg::KIND_RELAY_ON, 1'b0, 1'b0);
		send_item(pcbs_pkg::KIND_RELAY_OFF, 1'b1, 1'b1);
		send_item(pcbs_pkg::KIND_STOP, 1'b1, 1'b0);
		send_item(3'd5, 1'b1, 1'b1);
		send_item(3'd6, 1'b0, 1'b1);
		send_item(3'd7, 1'b1, 1'b1);
		send_item(pcbs_pkg::KIND_TICK, 1'b1, 1'b1);
	endtask

	// One short round with zero self-check: lamp one is confirmed, lamp two drops its check
	// and then leaves a pending check that power-off must discard.
	task automatic test_lamp_confirmation();
		program_times(26'd5, 26'd1, 26'd0);
		send_item(pcbs_pkg::KIND_START, 1'b0, 1'b0);
		send_item(pcbs_pkg::KIND_TICK, 1'b0, 1'b0);
		send_item(pcbs_pkg::KIND_TICK, 1'b1, 1'b1);
		send_item(pcbs_pkg::KIND_TICK, 1'b1, 1'b1);
		send_item(pcbs_pkg::KIND_TICK, 1'b0, 1'b1);
		send_item(pcbs_pkg::KIND_RELAY_OFF, 1'b0, 1'b0);
		send_item(pcbs_pkg::KIND_TICK, 1'b1, 1'b0);
		send_item(pcbs_pkg::KIND_TICK, 1'b0, 1'b1);
		send_item(pcbs_pkg::KIND_TICK, 1'b1, 1'b1);
		send_item(pcbs_pkg::KIND_TICK, 1'b0, 1'b0);
	endtask

	// A stop during self-check lets the check finish; the first monitoring tick powers off.
	// The longest on time and a zero off time are used here.
	task automatic test_stop_outside_monitoring();
		program_times(REG_MAX, 26'd0, 26'd2);
		send_item(pcbs_pkg::KIND_TICK, 1'b0, 1'b0);
		send_item(pcbs_pkg::KIND_TICK, 1'b1, 1'b1);
		send_item(pcbs_pkg::KIND_STOP, 1'b0, 1'b0);
		send_item(pcbs_pkg::KIND_TICK, 1'b1, 1'b1);
		send_item(pcbs_pkg::KIND_TICK, 1'b1, 1'b1);
		send_item(pcbs_pkg::KIND_TICK, 1'b0, 1'b0);
		send_item(pcbs_pkg::KIND_TICK, 1'b0, 1'b0);
	endtask

	// Random rounds under several timer settings: mostly ticks with slowly changing lamps,
	// mixed with start, stop, relay overrides and unused kinds.
	task automatic test_random_traffic();
		int p;
		int n;
		int r;
		logic [1:0] lamp;
		logic [pcbs_pkg::KIND_W-1:0] k;
		lamp = 2'b00;
		for (p = 0; p < 6; p++) begin
			if (p == 0)
				program_times(26'd0, 26'd0, 26'd0);
			else if (p == 5)
				program_times(pcbs_pkg::REG_W'($urandom_range(30, 60)),
						pcbs_pkg::REG_W'($urandom_range(0, 4)),
						pcbs_pkg::REG_W'($urandom_range(0, 4)));
			else
				program_times(pcbs_pkg::REG_W'($urandom_range(0, 20)),
						pcbs_pkg::REG_W'($urandom_range(0, 4)),
						pcbs_pkg::REG_W'($urandom_range(0, 4)));
			in_idle_on = (p != 3);
			out_idle_on = (p != 3);
			for (n = 0; n < 60; n++) begin
				if ($urandom_range(0, 3) == 0)
					lamp[0] = ~lamp[0];
				if ($urandom_range(0, 3) == 0)
					lamp[1] = ~lamp[1];
				r = $urandom_range(0, 99);
				if (r < 78)
					k = pcbs_pkg::KIND_TICK;
				else if (r < 85)
					k = pcbs_pkg::KIND_START;
				else if (r < 89)
					k = pcbs_pkg::KIND_STOP;
				else if (r < 92)
					k = pcbs_pkg::KIND_RELAY_ON;
				else if (r < 95)
					k = pcbs_pkg::KIND_RELAY_OFF;
				else
					k = pcbs_pkg::KIND_W'($urandom_range(5, 7));
				send_item(k, lamp[0], lamp[1]);
				// The sender waits here for the pipeline to empty completely.
				if (p == 2 && n == 40)
					wait_drained();
			end
		end
	endtask

	// Back-to-back seven-tick rounds with both lamps lit; each round counts one fault per lamp.
	task automatic test_back_to_back_rounds();
		in_idle_on = 1'b0;
		out_idle_on = 1'b0;
		send_item(pcbs_pkg::KIND_STOP, 1'b0, 1'b0);
		while (seq_phase != PH_IDLE)
			send_item(pcbs_pkg::KIND_TICK, 1'b0, 1'b0);
		program_times(26'd4, 26'd0, 26'd0);
		send_item(pcbs_pkg::KIND_START, 1'b0, 1'b0);
		repeat (70) send_item(pcbs_pkg::KIND_TICK, 1'b1, 1'b1);
	endtask

	// Largest register values: a new round stays in self-check.
	task automatic test_long_timers();
		program_times(REG_MAX, REG_MAX, REG_MAX);
		send_item(pcbs_pkg::KIND_TICK, 1'b1, 1'b1);
		repeat (4) send_item(pcbs_pkg::KIND_TICK, 1'b1, 1'b1);
		send_item(pcbs_pkg::KIND_RELAY_OFF, 1'b0, 1'b0);
		send_item(pcbs_pkg::KIND_TICK, 1'b1, 1'b1);
	endtask

	// Output side stall bursts.
	initial begin
		stall_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (out_idle_on && stall_left == 0 && $urandom_range(0, 5) == 0)
				stall_left = $urandom_range(1, 19);
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Compare each result transfer with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			seen_status = '{relay_drive, phase_now, rounds_done, lamp1_faults, lamp2_faults,
					round_end};
			if (expected_status.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: result transfer with nothing expected: relay=%0d phase=%0d",
							$time, seen_status.relay, seen_status.phase);
			end else begin
				if (seen_status !== expected_status[0]) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("%0t: expected relay=%0d phase=%0d rounds=%0d f1=%0d f2=%0d end=%0d",
								$time, expected_status[0].relay, expected_status[0].phase,
								expected_status[0].rounds, expected_status[0].lamp1_cnt,
								expected_status[0].lamp2_cnt, expected_status[0].ended);
						$display("%0t:      got relay=%0d phase=%0d rounds=%0d f1=%0d f2=%0d end=%0d",
								$time, seen_status.relay, seen_status.phase,
								seen_status.rounds, seen_status.lamp1_cnt,
								seen_status.lamp2_cnt, seen_status.ended);
					end
				end
				void'(expected_status.pop_front());
				results_checked++;
			end
		end
	end

	// Ends the run when nothing moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || wr_en) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("power_cycle_burnin_sequencer_unit test failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		in_valid = 1'b0;
		kind = pcbs_pkg::KIND_TICK;
		lamp1_on = 1'b0;
		lamp2_on = 1'b0;
		in_idle_on = 1'b1;
		out_idle_on = 1'b1;
		mismatch_count = 0;
		items_sent = 0;
		results_checked = 0;
		sched_cfg = '{pcbs_pkg::ON_TIME_RST, pcbs_pkg::OFF_TIME_RST, pcbs_pkg::SELFCHECK_RST};
		running_q = 1'b0;
		seq_phase = PH_IDLE;
		on_left = '0;
		phase_left = '0;
		fault_seen[0] = 1'b0;
		fault_seen[1] = 1'b0;
		confirm_left[0] = '0;
		confirm_left[1] = '0;
		round_cnt = '0;
		fault_cnt[0] = '0;
		fault_cnt[1] = '0;
		relay_q = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_idle_commands();
		test_lamp_confirmation();
		test_stop_outside_monitoring();
		test_random_traffic();
		test_back_to_back_rounds();
		test_long_timers();

		wait_drained();
		repeat (4) @(posedge clk);
		$display("Checked %0d results against %0d input transfers: commands, lamp checks,",
				results_checked, items_sent);
		$display("stops, timer extremes and back-to-back rounds (rounds %0d, faults %0d/%0d).",
				round_cnt, fault_cnt[0], fault_cnt[1]);
		if (mismatch_count == 0 && expected_status.size() == 0)
			$display("power_cycle_burnin_sequencer_unit test passed");
		else
			$display("power_cycle_burnin_sequencer_unit test failed");
		$finish;
	end

endmodule
`default_nettype wire

// File: filelist.f
rtl/pcbs_pkg.sv
rtl/pcbs_cfg.sv
rtl/pcbs_lamp.sv
rtl/pcbs_seq.sv
rtl/power_cycle_burnin_sequencer_unit.sv
sim/tb_power_cycle_burnin_sequencer_unit.sv
